// ===== hdl/bli_pkg.sv =====
// ============================================================================
// bli_pkg: shared types and constants for the battery level indicator
// Configuration record, front-to-back queue entry, charge constants and the
// band color table.
// ============================================================================
package bli_pkg;

    localparam int VoltW     = 16;
    localparam int ChargeW   = 15;
    localparam int BandW     = 3;
    localparam int PctW      = 7;
    localparam int HystW     = 6;
    localparam int CfgAddrW  = 3;
    localparam int CfgDataW  = 16;
    // numerator of the curve before the Q8 scale: at most 100 * 65535
    localparam int NumW      = 23;
    // quotient is at most 25600, so it fits in ChargeW bits
    localparam int DivSteps  = ChargeW;
    localparam int DivCntW   = $clog2(DivSteps);

    localparam logic [ChargeW-1:0] FULL_Q8  = ChargeW'(25600);
    localparam logic [BandW-1:0]   TOP_BAND = BandW'(4);
    localparam logic [PctW-1:0]    PCT_MAX  = PctW'(100);

    // configuration register indexes
    localparam logic [CfgAddrW-1:0] REG_FULL_MV    = CfgAddrW'(0);
    localparam logic [CfgAddrW-1:0] REG_EMPTY_MV   = CfgAddrW'(1);
    localparam logic [CfgAddrW-1:0] REG_KNEE_MV    = CfgAddrW'(2);
    localparam logic [CfgAddrW-1:0] REG_KNEE_PCT   = CfgAddrW'(3);
    localparam logic [CfgAddrW-1:0] REG_BAND_WIDTH = CfgAddrW'(4);
    localparam logic [CfgAddrW-1:0] REG_HYST       = CfgAddrW'(5);

    typedef struct packed {
        logic [VoltW-1:0] full_mv;
        logic [VoltW-1:0] empty_mv;
        logic [VoltW-1:0] knee_mv;
        logic [PctW-1:0]  knee_pct;
        logic [PctW-1:0]  band_width;
        logic [HystW-1:0] hyst;
    } cfg_t;

    // how the back end produces the charge of one item
    typedef enum logic [1:0] {
        KIND_FULL,   // above full voltage
        KIND_ZERO,   // below empty voltage
        KIND_FIXED,  // flat upper segment, charge = num * 256
        KIND_DIV     // charge = num * 256 / den
    } kind_t;

    typedef struct packed {
        kind_t            kind;
        logic [NumW-1:0]  num;
        logic [VoltW-1:0] den;
    } seg_item_t;

    // band color as {red, green, blue}
    function automatic logic [23:0] band_color(input logic [BandW-1:0] band);
        logic [23:0] rgb;
        unique case (band)
            3'd0:    rgb = {8'd255, 8'd0,   8'd0};
            3'd1:    rgb = {8'd255, 8'd50,  8'd0};
            3'd2:    rgb = {8'd255, 8'd255, 8'd0};
            3'd3:    rgb = {8'd100, 8'd255, 8'd0};
            default: rgb = {8'd0,   8'd255, 8'd0};
        endcase
        return rgb;
    endfunction

endpackage

// ===== hdl/bli_front.sv =====
// ============================================================================
// bli_front: sample intake and segment classification
// Accepts a voltage item, picks the curve segment and forms the numerator and
// divisor of the charge, then hands the entry to the queue.
// ============================================================================
module bli_front (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  bli_pkg::cfg_t            cfg,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [15:0]              s_voltage_mv,
    output logic                     push_valid,
    output bli_pkg::seg_item_t       push_item,
    input  logic                     push_ready
);
    import bli_pkg::*;

    typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} fstate_t;

    fstate_t          state_reg;
    logic [VoltW-1:0] volt_reg;
    kind_t            kind_reg;
    logic [NumW-1:0]  p1_reg;
    logic [NumW-1:0]  p2_reg;
    logic [VoltW-1:0] den_reg;

    logic [PctW-1:0]  kp;
    logic             above, below, upper, flat;
    logic [VoltW-1:0] sel_a, sel_b;
    kind_t            kind_next;
    logic [VoltW-1:0] den_next;
    logic [NumW-1:0]  p1_next, p2_next;

    // segment selection and products
    always_comb begin
        kp    = (cfg.knee_pct > PCT_MAX) ? PCT_MAX : cfg.knee_pct;
        above = volt_reg > cfg.full_mv;
        below = volt_reg < cfg.empty_mv;
        upper = volt_reg >= cfg.knee_mv;
        flat  = cfg.full_mv <= cfg.knee_mv;
        if (above) begin
            kind_next = KIND_FULL;
        end else if (below) begin
            kind_next = KIND_ZERO;
        end else if (upper && flat) begin
            kind_next = KIND_FIXED;
        end else begin
            kind_next = KIND_DIV;
        end
        if (upper) begin
            sel_a = flat ? VoltW'(1) : (cfg.full_mv - cfg.knee_mv);
            sel_b = flat ? '0 : (volt_reg - cfg.knee_mv);
            den_next = cfg.full_mv - cfg.knee_mv;
        end else begin
            sel_a = volt_reg - cfg.empty_mv;
            sel_b = '0;
            den_next = cfg.knee_mv - cfg.empty_mv;
        end
        p1_next = NumW'(kp) * NumW'(sel_a);
        p2_next = NumW'(sel_b) * NumW'(PCT_MAX - kp);
    end

    assign s_ready        = (state_reg == F_IDLE);
    assign push_valid     = (state_reg == F_PUSH);
    assign push_item.kind = kind_reg;
    assign push_item.num  = p1_reg + p2_reg;
    assign push_item.den  = den_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            unique case (state_reg)
                F_IDLE: begin
                    if (s_valid) begin
                        volt_reg  <= s_voltage_mv;
                        state_reg <= F_MUL;
                    end
                end
                F_MUL: begin
                    kind_reg  <= kind_next;
                    p1_reg    <= p1_next;
                    p2_reg    <= p2_next;
                    den_reg   <= den_next;
                    state_reg <= F_PUSH;
                end
                F_PUSH: begin
                    if (push_ready) begin
                        state_reg <= F_IDLE;
                    end
                end
                default: state_reg <= F_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/bli_fifo.sv =====
// ============================================================================
// bli_fifo: two-entry queue between front and back
// Holds classified items so intake and division stall independently.
// ============================================================================
module bli_fifo (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                push_valid,
    input  bli_pkg::seg_item_t  push_item,
    output logic                push_ready,
    output logic                pop_valid,
    output bli_pkg::seg_item_t  pop_item,
    input  logic                pop_ready
);
    import bli_pkg::*;

    seg_item_t  entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_item   = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill level
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (do_push) wr_ptr_reg <= ~wr_ptr_reg;
            if (do_pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 2'd1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

endmodule

// ===== hdl/bli_back.sv =====
// ============================================================================
// bli_back: charge division, band quantizer with hysteresis, result register
// Restoring divider, one quotient bit per cycle, then band decision and the
// output register of the result channel.
// ============================================================================
module bli_back (
    input  logic                aclk,
    input  logic                aresetn,
    input  bli_pkg::cfg_t       cfg,
    input  logic                pop_valid,
    input  bli_pkg::seg_item_t  pop_item,
    output logic                pop_ready,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [2:0]          m_band_index,
    output logic [14:0]         m_charge_q8,
    output logic [7:0]          m_red_level,
    output logic [7:0]          m_green_level,
    output logic [7:0]          m_blue_level
);
    import bli_pkg::*;

    typedef enum logic [1:0] {B_IDLE, B_DIV, B_RAW, B_DONE} bstate_t;

    bstate_t            state_reg;
    logic [VoltW-1:0]   rem_reg;
    logic [ChargeW-1:0] shift_reg;
    logic [VoltW-1:0]   den_reg;
    logic [DivCntW-1:0] cnt_reg;
    logic [ChargeW-1:0] charge_reg;
    logic [BandW-1:0]   raw_reg;
    logic [BandW-1:0]   band_reg;
    logic               seen_reg;
    logic               m_valid_reg;
    logic [BandW-1:0]   m_band_reg;
    logic [ChargeW-1:0] m_charge_reg;
    logic [23:0]        m_rgb_reg;

    logic [VoltW:0]     trial;
    logic [VoltW:0]     diff;
    logic               ge;
    logic [BandW-1:0]   raw_next;
    logic [BandW-1:0]   band_next;
    logic [9:0]         edge_k;
    logic [9:0]         cur_w;
    logic [9:0]         up_thr;
    logic signed [10:0] down_thr;
    logic               out_free;

    // one restoring division step
    always_comb begin
        trial = {rem_reg, shift_reg[ChargeW-1]};
        diff  = trial - {1'b0, den_reg};
        ge    = trial >= {1'b0, den_reg};
    end

    // raw band: count of band edges at or below the charge
    always_comb begin
        raw_next = '0;
        for (int k = 1; k <= 4; k++) begin
            edge_k = 10'(k) * 10'(cfg.band_width);
            if ({2'd0, charge_reg} >= {edge_k[8:0], 8'd0}) begin
                raw_next = raw_next + BandW'(1);
            end
        end
    end

    // hysteresis decision
    always_comb begin
        cur_w    = 10'(band_reg) * 10'(cfg.band_width);
        up_thr   = 10'(raw_reg) * 10'(cfg.band_width) + 10'(cfg.hyst);
        down_thr = $signed({1'b0, cur_w}) - $signed({5'd0, cfg.hyst});
        band_next = band_reg;
        if (!seen_reg) begin
            band_next = raw_reg;
        end else if (raw_reg < band_reg) begin
            if (!down_thr[10] && ({3'd0, charge_reg} <= {down_thr[9:0], 8'd0})) begin
                band_next = raw_reg;
            end
        end else if (raw_reg > band_reg) begin
            if ({3'd0, charge_reg} >= {up_thr, 8'd0}) begin
                band_next = raw_reg;
            end
        end
    end

    assign out_free      = !m_valid_reg || m_ready;
    assign pop_ready     = (state_reg == B_IDLE);
    assign m_valid       = m_valid_reg;
    assign m_band_index  = m_band_reg;
    assign m_charge_q8   = m_charge_reg;
    assign m_red_level   = m_rgb_reg[23:16];
    assign m_green_level = m_rgb_reg[15:8];
    assign m_blue_level  = m_rgb_reg[7:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= B_IDLE;
            band_reg    <= '0;
            seen_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // result taken and nothing new loaded this cycle
            if (m_valid_reg && m_ready && state_reg != B_DONE) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                B_IDLE: begin
                    if (pop_valid) begin
                        unique case (pop_item.kind)
                            KIND_DIV: begin
                                rem_reg   <= pop_item.num[NumW-1:NumW-VoltW];
                                shift_reg <= {pop_item.num[NumW-VoltW-1:0], 8'd0};
                                den_reg   <= pop_item.den;
                                cnt_reg   <= '0;
                                state_reg <= B_DIV;
                            end
                            KIND_FULL: begin
                                charge_reg <= FULL_Q8;
                                state_reg  <= B_RAW;
                            end
                            KIND_ZERO: begin
                                charge_reg <= '0;
                                state_reg  <= B_RAW;
                            end
                            default: begin
                                charge_reg <= {pop_item.num[PctW-1:0], 8'd0};
                                state_reg  <= B_RAW;
                            end
                        endcase
                    end
                end
                B_DIV: begin
                    rem_reg   <= ge ? diff[VoltW-1:0] : trial[VoltW-1:0];
                    shift_reg <= {shift_reg[ChargeW-2:0], ge};
                    cnt_reg   <= cnt_reg + DivCntW'(1);
                    if (cnt_reg == DivCntW'(DivSteps - 1)) begin
                        charge_reg <= {shift_reg[ChargeW-2:0], ge};
                        state_reg  <= B_RAW;
                    end
                end
                B_RAW: begin
                    raw_reg   <= raw_next;
                    state_reg <= B_DONE;
                end
                B_DONE: begin
                    if (out_free) begin
                        band_reg     <= band_next;
                        seen_reg     <= 1'b1;
                        m_band_reg   <= band_next;
                        m_charge_reg <= charge_reg;
                        m_rgb_reg    <= band_color(band_next);
                        m_valid_reg  <= 1'b1;
                        state_reg    <= B_IDLE;
                    end
                end
                default: state_reg <= B_IDLE;
            endcase
        end
    end

endmodule

// ===== hdl/battery_level_indicator_core.sv =====
// ============================================================================
// battery_level_indicator_core: battery gauge with hysteresis band quantizer
// Maps a voltage sample to a Q7.8 charge on a two-segment curve, quantizes it
// into five color bands with hysteresis and returns band, charge and color.
//
//   channel  | ports                                  | handshake
//   ---------+----------------------------------------+-----------------
//   input    | s_voltage_mv                           | s_valid/s_ready
//   result   | m_band_index m_charge_q8 m_*_level     | m_valid/m_ready
//   config   | cfg_addr cfg_wdata                     | cfg_we, no wait
//
// An item passes the front's idle, multiply and push states, then the back's
// idle, divide, raw-band and result states; the restoring divider (one quotient
// bit per cycle, 15 steps) bounds the sustained rate on interpolated segments.
// A two-entry queue sits between front and back, and the result register
// lets the back start the next item once its result is loaded.
// Reset (aresetn, synchronous) clears the band, the first-sample flag and
// restores the configuration defaults.
// ============================================================================
module battery_level_indicator_core (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         cfg_we,
    input  logic [bli_pkg::CfgAddrW-1:0] cfg_addr,
    input  logic [bli_pkg::CfgDataW-1:0] cfg_wdata,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [15:0]                  s_voltage_mv,
    output logic                         m_valid,
    input  logic                         m_ready,
    output logic [2:0]                   m_band_index,
    output logic [14:0]                  m_charge_q8,
    output logic [7:0]                   m_red_level,
    output logic [7:0]                   m_green_level,
    output logic [7:0]                   m_blue_level
);
    import bli_pkg::*;

    cfg_t      cfg_reg;
    logic      push_valid, push_ready;
    seg_item_t push_item;
    logic      pop_valid, pop_ready;
    seg_item_t pop_item;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.full_mv    <= VoltW'(8250);
            cfg_reg.empty_mv   <= VoltW'(5800);
            cfg_reg.knee_mv    <= VoltW'(7200);
            cfg_reg.knee_pct   <= PctW'(15);
            cfg_reg.band_width <= PctW'(20);
            cfg_reg.hyst       <= HystW'(5);
        end else if (cfg_we) begin
            case (cfg_addr)
                REG_FULL_MV:    cfg_reg.full_mv    <= cfg_wdata;
                REG_EMPTY_MV:   cfg_reg.empty_mv   <= cfg_wdata;
                REG_KNEE_MV:    cfg_reg.knee_mv    <= cfg_wdata;
                REG_KNEE_PCT:   cfg_reg.knee_pct   <= cfg_wdata[PctW-1:0];
                REG_BAND_WIDTH: cfg_reg.band_width <= cfg_wdata[PctW-1:0];
                REG_HYST:       cfg_reg.hyst       <= cfg_wdata[HystW-1:0];
                default: ;
            endcase
        end
    end

    bli_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg          (cfg_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_voltage_mv (s_voltage_mv),
        .push_valid   (push_valid),
        .push_item    (push_item),
        .push_ready   (push_ready)
    );

    bli_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_item  (push_item),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_item   (pop_item),
        .pop_ready  (pop_ready)
    );

    bli_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg           (cfg_reg),
        .pop_valid     (pop_valid),
        .pop_item      (pop_item),
        .pop_ready     (pop_ready),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_band_index  (m_band_index),
        .m_charge_q8   (m_charge_q8),
        .m_red_level   (m_red_level),
        .m_green_level (m_green_level),
        .m_blue_level  (m_blue_level)
    );

endmodule
